// ===== rtl/core/vsa_pkg.sv =====
package vsa_pkg;

  // item field widths
  localparam int unsigned VectorW = 8;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned RefW    = 64;

  typedef enum logic {
    OP_ALLOC  = 1'b0,
    OP_ATTACH = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_VECTOR = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NOT_TAKEN = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

endpackage

// ===== rtl/core/vsa_ram.sv =====
module vsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/vector_and_handler_slot_allocator_unit.sv =====
// a result is registered as its item leaves the execute state; the item waits there while an earlier result is stalled
// the block takes no new item until the last one leaves the execute state; for an attach the slot
//   memory row is read at accept and written back when the item completes
// a waiting result does not block the next input transaction
// reset (asynchronous, active low) clears the taken marks at once; no clearing
//   pass is needed, handler and argument entries are undefined until written
module vector_and_handler_slot_allocator_unit #(
  parameter int unsigned NUM_VECTORS      = 64,
  parameter int unsigned SLOTS_PER_VECTOR = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  hint_vector_i,
  input  logic [7:0]  target_vector_i,
  input  logic [63:0] handler_ref_i,
  input  logic [63:0] handler_arg_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  granted_vector_o,
  output logic [3:0]  granted_slot_o
);

  localparam int unsigned VecW    = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
  localparam int unsigned SIdxW   = (SLOTS_PER_VECTOR > 1) ? $clog2(SLOTS_PER_VECTOR) : 1;
  localparam int unsigned TotSlot = NUM_VECTORS * SLOTS_PER_VECTOR;
  localparam int unsigned HAddrW  = (TotSlot > 1) ? $clog2(TotSlot) : 1;
  localparam int unsigned RefW    = vsa_pkg::RefW;

  vsa_pkg::fsm_e state_q, state_d;

  // latched transaction
  vsa_pkg::op_e                 op_q;
  logic [vsa_pkg::VectorW-1:0] hint_q;
  logic [vsa_pkg::VectorW-1:0] target_q;
  logic [RefW-1:0]              ref_q;
  logic [RefW-1:0]              arg_q;

  logic [NUM_VECTORS-1:0] taken_q, taken_d;

  logic                         out_valid_q, out_valid_d;
  vsa_pkg::status_e             status_q, status_d;
  logic [vsa_pkg::VectorW-1:0] gvec_q, gvec_d;
  logic [vsa_pkg::SlotW-1:0]   gslot_q, gslot_d;

  logic in_accept;
  logic done;

  // slot memory ports
  logic                        row_rd_en;
  logic [VecW-1:0]             row_rd_addr;
  logic [SLOTS_PER_VECTOR-1:0] row_rd_data;
  logic                        row_wr_en;
  logic [VecW-1:0]             row_wr_addr;
  logic [SLOTS_PER_VECTOR-1:0] row_wr_data;

  // handler memory ports
  logic              hdl_wr_en;
  logic [HAddrW-1:0] hdl_wr_addr;

  // search results
  logic [NUM_VECTORS-1:0] free_mask, upper_mask;
  logic [VecW-1:0]        start_idx, found_idx;
  logic                   any_free, any_upper;
  logic [VecW-1:0]        upper_idx, low_idx;
  logic [SIdxW-1:0]       slot_idx;
  logic                   any_slot;
  logic                   hint_in_range, target_in_range;
  logic [VecW-1:0]        target_idx;

  assign in_stall_o  = (state_q != vsa_pkg::S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign done        = (state_q == vsa_pkg::S_EXEC) && (!out_valid_q || !out_stall_i);

  assign row_rd_en   = in_accept && (opcode_i == vsa_pkg::OP_ATTACH);
  assign row_rd_addr = target_vector_i[VecW-1:0];

  assign hint_in_range   = {1'b0, hint_q} < 9'(NUM_VECTORS);
  assign target_in_range = {1'b0, target_q} < 9'(NUM_VECTORS);
  assign start_idx       = hint_in_range ? hint_q[VecW-1:0] : '0;
  assign target_idx      = target_q[VecW-1:0];

  // first free vector at or above the start, and first free overall
  always_comb begin
    free_mask  = ~taken_q;
    upper_mask = '0;
    any_free   = 1'b0;
    any_upper  = 1'b0;
    upper_idx  = '0;
    low_idx    = '0;
    for (int i = NUM_VECTORS - 1; i >= 0; i--) begin
      upper_mask[i] = free_mask[i] && (VecW'(i) >= start_idx);
      if (upper_mask[i]) begin
        upper_idx = VecW'(i);
        any_upper = 1'b1;
      end
      if (free_mask[i]) begin
        low_idx  = VecW'(i);
        any_free = 1'b1;
      end
    end
    found_idx = any_upper ? upper_idx : low_idx;
  end

  // lowest empty slot of the row just read
  always_comb begin
    slot_idx = '0;
    any_slot = 1'b0;
    for (int s = SLOTS_PER_VECTOR - 1; s >= 0; s--) begin
      if (!row_rd_data[s]) begin
        slot_idx = SIdxW'(s);
        any_slot = 1'b1;
      end
    end
  end

  // next state, result and write-back
  always_comb begin
    state_d     = state_q;
    taken_d     = taken_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    gvec_d      = gvec_q;
    gslot_d     = gslot_q;
    row_wr_en   = 1'b0;
    row_wr_addr = found_idx;
    row_wr_data = '0;
    hdl_wr_en   = 1'b0;
    hdl_wr_addr = HAddrW'(target_idx) * HAddrW'(SLOTS_PER_VECTOR) + HAddrW'(slot_idx);

    case (state_q)
      vsa_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = vsa_pkg::S_EXEC;
        end
      end
      vsa_pkg::S_EXEC: begin
        if (done) begin
          state_d     = vsa_pkg::S_IDLE;
          out_valid_d = 1'b1;
          gvec_d      = '0;
          gslot_d     = '0;
          if (op_q == vsa_pkg::OP_ALLOC) begin
            if (any_free) begin
              status_d           = vsa_pkg::ST_OK;
              gvec_d             = vsa_pkg::VectorW'(found_idx);
              taken_d[found_idx] = 1'b1;
              row_wr_en          = 1'b1;
            end else begin
              status_d = vsa_pkg::ST_NO_VECTOR;
            end
          end else if (!target_in_range) begin
            status_d = vsa_pkg::ST_RANGE;
          end else if (!taken_q[target_idx]) begin
            status_d = vsa_pkg::ST_NOT_TAKEN;
          end else if (!any_slot) begin
            status_d = vsa_pkg::ST_NO_SLOT;
          end else begin
            status_d              = vsa_pkg::ST_OK;
            gslot_d               = vsa_pkg::SlotW'(slot_idx);
            row_wr_en             = 1'b1;
            row_wr_addr           = target_idx;
            row_wr_data           = row_rd_data;
            row_wr_data[slot_idx] = (ref_q != '0);
            hdl_wr_en             = 1'b1;
          end
        end
      end
      default: begin
        state_d = vsa_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsa_pkg::S_IDLE;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= vsa_pkg::op_e'(opcode_i);
      hint_q   <= hint_vector_i;
      target_q <= target_vector_i;
      ref_q    <= handler_ref_i;
      arg_q    <= handler_arg_i;
    end
    status_q <= status_d;
    gvec_q   <= gvec_d;
    gslot_q  <= gslot_d;
  end

  // slot used marks, one row per vector
  vsa_ram #(
    .WIDTH (SLOTS_PER_VECTOR),
    .DEPTH (NUM_VECTORS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (row_wr_en),
    .wr_addr_i (row_wr_addr),
    .wr_data_i (row_wr_data),
    .rd_en_i   (row_rd_en),
    .rd_addr_i (row_rd_addr),
    .rd_data_o (row_rd_data)
  );

  // handler reference and argument per slot
  vsa_ram #(
    .WIDTH (2 * RefW),
    .DEPTH (TotSlot)
  ) u_handler_ram (
    .clk_i     (clk_i),
    .wr_en_i   (hdl_wr_en),
    .wr_addr_i (hdl_wr_addr),
    .wr_data_i ({ref_q, arg_q}),
    .rd_en_i   (1'b0),
    .rd_addr_i (hdl_wr_addr),
    .rd_data_o ()
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_vector_o = gvec_q;
  assign granted_slot_o   = gslot_q;

endmodule

// ===== rtl/core/vsa_checker.sv =====
module vsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [7:0]  granted_vector_o,
  input logic [3:0]  granted_slot_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_vector_o) && $stable(granted_slot_o))
    else $error("stalled result changed");

  // failed transactions grant nothing
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != vsa_pkg::ST_OK) |->
      (granted_vector_o == '0) && (granted_slot_o == '0))
    else $error("grant on failed transaction");

  // the block is busy the cycle after an accepted transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // a new result only appears while an item is in work
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

endmodule

bind vector_and_handler_slot_allocator_unit vsa_checker u_vsa_checker (.*);
